@@ design/hmb_pkg.sv @@
// Shared types, constants and Morse code tables for the hex Morse blinker.
package hmb_pkg;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_LIGHT  = 3'd1,
		PH_DARK   = 3'd2,
		PH_LETTER = 3'd3,
		PH_WORD   = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		REG_DOT_TICKS = 2'd0,
		REG_ON_LEVEL  = 2'd1,
		REG_OFF_LEVEL = 2'd2
	} reg_idx_t;

	localparam logic [15:0] DOT_TICKS_RST = 16'd50;
	localparam logic        ON_LEVEL_RST  = 1'b1;
	localparam logic        OFF_LEVEL_RST = 1'b0;

	localparam logic [2:0] UNITS_DOT    = 3'd1;
	localparam logic [2:0] UNITS_DASH   = 3'd3;
	localparam logic [2:0] UNITS_LETTER = 3'd3;
	localparam logic [2:0] UNITS_WORD   = 3'd7;

	// one result item
	typedef struct packed {
		logic finished;
		logic busy_res;
		logic led_level;
	} res_t;

	// number of elements in the code of a hex digit
	function automatic logic [2:0] code_len(input logic [3:0] dig);
		logic [2:0] len;
		case (dig)
			4'hA:    len = 3'd2;
			4'hB:    len = 3'd4;
			4'hC:    len = 3'd4;
			4'hD:    len = 3'd3;
			4'hE:    len = 3'd1;
			4'hF:    len = 3'd4;
			default: len = 3'd5;
		endcase
		return len;
	endfunction

	// bit i set: element i of the digit is a dash
	function automatic logic [4:0] code_dash(input logic [3:0] dig);
		logic [4:0] mask;
		case (dig)
			4'h0:    mask = 5'h1F;
			4'h1:    mask = 5'h1E;
			4'h2:    mask = 5'h1C;
			4'h3:    mask = 5'h18;
			4'h4:    mask = 5'h10;
			4'h5:    mask = 5'h00;
			4'h6:    mask = 5'h01;
			4'h7:    mask = 5'h03;
			4'h8:    mask = 5'h07;
			4'h9:    mask = 5'h0F;
			4'hA:    mask = 5'h02;
			4'hB:    mask = 5'h01;
			4'hC:    mask = 5'h05;
			4'hD:    mask = 5'h01;
			4'hE:    mask = 5'h00;
			4'hF:    mask = 5'h04;
			default: mask = 5'h00;
		endcase
		return mask;
	endfunction

	// units of light for element e of a digit
	function automatic logic [2:0] elem_units(input logic [3:0] dig, input logic [2:0] e);
		logic [4:0] mask;
		logic       dash;
		mask = code_dash(dig);
		dash = (e < 3'd5) ? mask[e] : 1'b0;
		return dash ? UNITS_DASH : UNITS_DOT;
	endfunction

	// nibble idx of a 16-bit value, zero above the fourth nibble
	function automatic logic [3:0] nibble_at(input logic [15:0] val, input logic [4:0] idx);
		logic [3:0] nib;
		nib = 4'h0;
		if (idx < 5'd4)
			nib = val[{idx[1:0], 2'b00} +: 4];
		return nib;
	endfunction

endpackage

@@ design/hmb_core.sv @@
// Sequencing state of the blinker: digit, element and unit counters per item.
module hmb_core import hmb_pkg::*; #(
	parameter int DIGITS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic        opcode,
	input  logic [15:0] hex_value,
	input  logic [15:0] dot_ticks,
	input  logic        on_level,
	input  logic        off_level,
	output res_t        res
);

	localparam int DW = (DIGITS > 1) ? $clog2(DIGITS) : 1;

	logic [15:0] shown_q, shown_n;
	logic [DW-1:0] digit_q, digit_n;
	logic [2:0]  elem_q, elem_n;
	logic [15:0] unit_q, unit_n;
	logic [2:0]  left_q, left_n;
	phase_t      phase_q, phase_n;
	logic        fin_n;

	logic [DW-1:0] top_digit;
	logic [3:0]  top_nib;
	logic [3:0]  cur_nib;
	logic [3:0]  prev_nib;
	logic [DW-1:0] digit_dec;
	logic [15:0] limit;
	logic [15:0] unit_inc;
	logic [2:0]  left_dec;
	logic [2:0]  elem_inc;

	// highest nonzero digit of the incoming value, digit 0 at least
	always_comb begin
		top_digit = '0;
		for (int d = 1; d < 4; d++) begin
			if (d < DIGITS && hex_value[4*d +: 4] != 4'h0)
				top_digit = DW'(d);
		end
		top_nib = nibble_at(hex_value, 5'(top_digit));
	end

	assign digit_dec = digit_q - DW'(1);
	assign cur_nib   = nibble_at(shown_q, 5'(digit_q));
	assign prev_nib  = nibble_at(shown_q, 5'(digit_dec));
	assign limit     = (dot_ticks == 16'd0) ? 16'd1 : dot_ticks;
	assign unit_inc  = unit_q + 16'd1;
	assign left_dec  = left_q - 3'd1;
	assign elem_inc  = elem_q + 3'd1;

	// next state
	always_comb begin
		shown_n = shown_q;
		digit_n = digit_q;
		elem_n  = elem_q;
		unit_n  = unit_q;
		left_n  = left_q;
		phase_n = phase_q;
		fin_n   = 1'b0;
		if (opcode) begin
			if (phase_q == PH_IDLE) begin
				shown_n = hex_value;
				digit_n = top_digit;
				elem_n  = 3'd0;
				phase_n = PH_LIGHT;
				left_n  = elem_units(top_nib, 3'd0);
				unit_n  = 16'd0;
			end
		end else if (phase_q != PH_IDLE) begin
			unit_n = unit_inc;
			if (unit_inc >= limit) begin
				unit_n = 16'd0;
				left_n = left_dec;
				if (left_dec == 3'd0) begin
					case (phase_q)
						PH_LIGHT: begin
							phase_n = PH_DARK;
							left_n  = UNITS_DOT;
						end
						PH_DARK: begin
							elem_n = elem_inc;
							if (elem_inc < code_len(cur_nib)) begin
								phase_n = PH_LIGHT;
								left_n  = elem_units(cur_nib, elem_inc);
							end else begin
								phase_n = PH_LETTER;
								left_n  = UNITS_LETTER;
							end
						end
						PH_LETTER: begin
							if (digit_q == '0) begin
								phase_n = PH_WORD;
								left_n  = UNITS_WORD;
							end else begin
								digit_n = digit_dec;
								elem_n  = 3'd0;
								phase_n = PH_LIGHT;
								left_n  = elem_units(prev_nib, 3'd0);
							end
						end
						default: begin
							phase_n = PH_IDLE;
							left_n  = 3'd0;
							elem_n  = 3'd0;
							digit_n = '0;
							fin_n   = 1'b1;
						end
					endcase
				end
			end
		end
	end

	// result of this item, from the state it leaves
	always_comb begin
		res.led_level = (phase_n == PH_LIGHT) ? on_level : off_level;
		res.busy_res  = (phase_n != PH_IDLE);
		res.finished  = fin_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shown_q <= '0;
			digit_q <= '0;
			elem_q  <= '0;
			unit_q  <= '0;
			left_q  <= '0;
			phase_q <= PH_IDLE;
		end else if (accept) begin
			shown_q <= shown_n;
			digit_q <= digit_n;
			elem_q  <= elem_n;
			unit_q  <= unit_n;
			left_q  <= left_n;
			phase_q <= phase_n;
		end
	end

endmodule

@@ design/hmb_skid.sv @@
// Output register with a one-entry skid stage, so one more input transfer is taken while the output stalls.
module hmb_skid import hmb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  res_t in_res,
	output logic out_valid,
	input  logic out_ready,
	output res_t out_res
);

	logic out_v_q;
	res_t out_q;
	logic skid_v_q;
	res_t skid_q;
	logic take;
	logic load;

	assign in_ready  = !skid_v_q;
	assign out_valid = out_v_q;
	assign out_res   = out_q;
	assign take      = out_v_q && out_ready;
	assign load      = in_valid && !skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || take) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= load;
			end
		end else if (load) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || take) begin
			if (skid_v_q)
				out_q <= skid_q;
			else if (load)
				out_q <= in_res;
		end else if (load) begin
			skid_q <= in_res;
		end
	end

endmodule

@@ design/hex_morse_blinker.sv @@
// Top level: blinks a 16-bit value as hex Morse digits, one result per input transfer.
//
//  channel  dir   signals                               carries
//  s_*      in    tvalid tready tdata[15:0] tuser       hex_value, opcode (1 = start)
//  m_*      out   tvalid tready tdata[7:0] tlast        led_level, busy_res, finished
//  apb      in    psel penable pwrite paddr pwdata ...  dot_ticks, on_level, off_level
//
// One input transfer per cycle while s_tready is high; the result of each transfer is registered for m_*.
// Sequencing state updates at the transfer; the result register and a
// one-entry skid stage keep s_tready high while one result waits on a stalled m_tready.
// Reset clears the sequencer to idle and the registers to 50 ticks, on 1, off 0.
module hex_morse_blinker import hmb_pkg::*; #(
	parameter int DIGITS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] hex_value
	input  logic        s_tuser,   // [0] opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [0] led_level, [1] busy_res, [7:2] zero
	output logic        m_tlast,   // finished
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [15:0] dot_ticks_q;
	logic        on_level_q;
	logic        off_level_q;
	logic        accept;
	logic        cfg_wr;
	res_t        core_res;
	res_t        out_res;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_ticks_q <= DOT_TICKS_RST;
			on_level_q  <= ON_LEVEL_RST;
			off_level_q <= OFF_LEVEL_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_DOT_TICKS: dot_ticks_q <= pwdata[15:0];
				REG_ON_LEVEL:  on_level_q  <= pwdata[0];
				REG_OFF_LEVEL: off_level_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_DOT_TICKS: prdata = {16'd0, dot_ticks_q};
			REG_ON_LEVEL:  prdata = {31'd0, on_level_q};
			REG_OFF_LEVEL: prdata = {31'd0, off_level_q};
			default:       prdata = 32'd0;
		endcase
	end

	hmb_core #(
		.DIGITS(DIGITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.opcode   (s_tuser),
		.hex_value(s_tdata),
		.dot_ticks(dot_ticks_q),
		.on_level (on_level_q),
		.off_level(off_level_q),
		.res      (core_res)
	);

	hmb_skid u_skid (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_res   (core_res),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_res  (out_res)
	);

	assign m_tdata = {6'd0, out_res.busy_res, out_res.led_level};
	assign m_tlast = out_res.finished;

endmodule

@@ tb/sv/hex_morse_blinker_test.sv @@
// Self-checking testbench for hex_morse_blinker: predicts and checks every Morse result.
`timescale 1ns / 1ps

module hex_morse_blinker_test;
	import hmb_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_REPORTS = 10;

	// per hex digit, F down to 0: element count, and dash mask (bit i: element i is a dash)
	localparam logic [15:0][2:0] MORSE_LEN = {3'd4, 3'd1, 3'd3, 3'd4, 3'd4, 3'd2,
		3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5};
	localparam logic [15:0][7:0] DIGIT_DASH = {8'h04, 8'h00, 8'h01, 8'h05, 8'h01, 8'h02,
		8'h0F, 8'h07, 8'h03, 8'h01, 8'h00, 8'h10, 8'h18, 8'h1C, 8'h1E, 8'h1F};

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // [15:0] hex_value
	logic        s_tuser;   // [0] opcode
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // [0] led_level, [1] busy_res, [7:2] zero
	logic        m_tlast;   // finished
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// keyer model state and its copy of the registers
	logic [15:0] cfg_dot_ticks;
	logic        cfg_on_level;
	logic        cfg_off_level;
	phase_t      key_phase;
	logic [15:0] key_value;
	logic [1:0]  key_digit;
	logic [2:0]  key_elem;
	logic [15:0] key_ticks;
	logic [2:0]  key_units;

	res_t pending_results [$];
	int   accepted_items = 0;
	int   mismatches = 0;
	int   cycle_count = 0;
	int   src_idle_pct = 0;
	int   sink_idle_pct = 0;
	int   hold_cycles = 0;

	hex_morse_blinker dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void note_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("mismatch %s at %0t: expected %0h, got %0h", what, $time, want, got);
	endfunction

	function automatic logic [3:0] digit_of(input logic [1:0] d);
		return key_value[{d, 2'b00} +: 4];
	endfunction

	function automatic void light_element();
		key_phase = PH_LIGHT;
		key_units = DIGIT_DASH[digit_of(key_digit)][key_elem] ? UNITS_DASH : UNITS_DOT;
		key_ticks = '0;
	endfunction

	// advances the keyer by one input item and returns the LED result it causes
	function automatic res_t keyer_step(input logic start, input logic [15:0] val);
		logic [15:0] unit_len;
		logic [1:0]  top;
		res_t        r;
		r.finished = 1'b0;
		if (start) begin
			// a start while sending is dropped and does not advance time
			if (key_phase == PH_IDLE) begin
				key_value = val;
				top = 2'd3;
				while (top != 2'd0 && digit_of(top) == 4'h0)
					top--;
				key_digit = top;
				key_elem = '0;
				light_element();
			end
		end else if (key_phase != PH_IDLE) begin
			unit_len = (cfg_dot_ticks == 16'd0) ? 16'd1 : cfg_dot_ticks;
			key_ticks = key_ticks + 16'd1;
			if (key_ticks >= unit_len) begin
				key_ticks = '0;
				key_units = key_units - 3'd1;
				if (key_units == 3'd0) begin
					case (key_phase)
						PH_LIGHT: begin
							key_phase = PH_DARK;
							key_units = 3'd1;
						end
						PH_DARK: begin
							key_elem = key_elem + 3'd1;
							if (key_elem < MORSE_LEN[digit_of(key_digit)]) begin
								light_element();
							end else begin
								key_phase = PH_LETTER;
								key_units = UNITS_LETTER;
							end
						end
						PH_LETTER: begin
							if (key_digit == 2'd0) begin
								key_phase = PH_WORD;
								key_units = UNITS_WORD;
							end else begin
								key_digit = key_digit - 2'd1;
								key_elem = '0;
								light_element();
							end
						end
						default: begin
							key_phase = PH_IDLE;
							key_units = '0;
							key_elem = '0;
							key_digit = '0;
							r.finished = 1'b1;
						end
					endcase
				end
			end
		end
		r.led_level = (key_phase == PH_LIGHT) ? cfg_on_level : cfg_off_level;
		r.busy_res = (key_phase != PH_IDLE);
		return r;
	endfunction

	task automatic send_item(input logic start, input logic [15:0] val);
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = start;
		s_tdata = val;
		do
			@(posedge clk);
		while (!s_tready);
		pending_results.push_back(keyer_step(start, val));
		accepted_items++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic reg_write(input reg_idx_t idx, input logic [15:0] val);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = {16'h0, val};
		@(negedge clk);
		penable = 1'b1;
		do
			@(posedge clk);
		while (!pready);
		case (idx)
			REG_DOT_TICKS: cfg_dot_ticks = val;
			REG_ON_LEVEL:  cfg_on_level = val[0];
			default:       cfg_off_level = val[0];
		endcase
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic reg_read(input reg_idx_t idx);
		logic [31:0] want;
		case (idx)
			REG_DOT_TICKS: want = {16'h0, cfg_dot_ticks};
			REG_ON_LEVEL:  want = {31'h0, cfg_on_level};
			default:       want = {31'h0, cfg_off_level};
		endcase
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = {idx, 2'b00};
		@(negedge clk);
		penable = 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (prdata !== want)
			note_mismatch("register read", want, prdata);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	// ticks until the model says the word gap is over; some starts are thrown in as noise
	task automatic ticks_until_idle(input int noise_pct);
		while (key_phase != PH_IDLE) begin
			if ($urandom_range(0, 99) < noise_pct)
				send_item(1'b1, 16'($urandom_range(0, 16'hFFFF)));
			else
				send_item(1'b0, 16'($urandom_range(0, 16'hFFFF)));
		end
	endtask

	task automatic test_register_access();
		reg_read(REG_DOT_TICKS);
		reg_read(REG_ON_LEVEL);
		reg_read(REG_OFF_LEVEL);
		reg_write(REG_DOT_TICKS, 16'hFFFF);
		reg_read(REG_DOT_TICKS);
		reg_write(REG_DOT_TICKS, 16'd1);
		reg_read(REG_DOT_TICKS);
	endtask

	task automatic test_zero_value();
		// ticks while idle change nothing
		send_item(1'b0, 16'hFFFF);
		send_item(1'b0, 16'h0000);
		// only the last digit goes out: five dashes
		send_item(1'b1, 16'h0000);
		ticks_until_idle(10);
		wait_drained();
	endtask

	task automatic test_all_ones_zero_unit();
		reg_write(REG_DOT_TICKS, 16'd0);
		send_item(1'b1, 16'hFFFF);
		ticks_until_idle(0);
		wait_drained();
		reg_read(REG_DOT_TICKS);
	endtask

	task automatic test_level_swap();
		reg_write(REG_DOT_TICKS, 16'd1);
		reg_write(REG_ON_LEVEL, 16'd0);
		reg_write(REG_OFF_LEVEL, 16'd1);
		send_item(1'b1, 16'h0E00);
		repeat (3) send_item(1'b0, 16'h0000);
		wait_drained();
		// levels changed mid-word
		reg_write(REG_ON_LEVEL, 16'd1);
		repeat (3) send_item(1'b0, 16'h0000);
		wait_drained();
		reg_write(REG_ON_LEVEL, 16'd0);
		reg_write(REG_OFF_LEVEL, 16'd0);
		ticks_until_idle(0);
		wait_drained();
		reg_read(REG_ON_LEVEL);
		reg_read(REG_OFF_LEVEL);
		reg_write(REG_ON_LEVEL, 16'd1);
	endtask

	task automatic test_unit_shrink();
		reg_write(REG_DOT_TICKS, 16'hFFFF);
		send_item(1'b1, 16'h8421);
		repeat (20) send_item(1'b0, 16'h0000);
		wait_drained();
		// counter already past the new unit length: unit ends on the next tick
		reg_write(REG_DOT_TICKS, 16'd2);
		ticks_until_idle(0);
		wait_drained();
	endtask

	task automatic test_backpressure();
		reg_write(REG_DOT_TICKS, 16'd1);
		@(posedge clk);
		hold_cycles = 80;
		send_item(1'b1, 16'hC3A5);
		ticks_until_idle(0);
		wait_drained();
	endtask

	task automatic test_random_traffic(input int n_items, input int src_pct, input int sink_pct);
		int          stop_at;
		int          n_digits;
		logic [15:0] val;
		src_idle_pct = src_pct;
		sink_idle_pct = sink_pct;
		stop_at = accepted_items + n_items;
		while (accepted_items < stop_at) begin
			wait_drained();
			case ($urandom_range(0, 9))
				0:       reg_write(REG_DOT_TICKS, 16'd0);
				1, 2:    reg_write(REG_DOT_TICKS, 16'd2);
				3:       reg_write(REG_DOT_TICKS, 16'd3);
				default: reg_write(REG_DOT_TICKS, 16'd1);
			endcase
			if ($urandom_range(0, 3) == 0) begin
				reg_write(REG_ON_LEVEL, 16'($urandom_range(0, 1)));
				reg_write(REG_OFF_LEVEL, 16'($urandom_range(0, 1)));
			end
			repeat ($urandom_range(0, 2))
				send_item(1'b0, 16'($urandom_range(0, 16'hFFFF)));
			// mostly short words so that many complete
			n_digits = $urandom_range(1, 4);
			val = 16'($urandom_range(0, 16'hFFFF)) & (16'hFFFF >> (4 * (4 - n_digits)));
			send_item(1'b1, val);
			ticks_until_idle(4);
		end
		wait_drained();
	endtask

	// result sink: random stalls, plus long hold-offs on request
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles--;
			m_tready = 1'b0;
		end else begin
			m_tready = ($urandom_range(0, 99) >= sink_idle_pct);
		end
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				note_mismatch("result with nothing pending", 32'h0, {23'h0, m_tlast, m_tdata});
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[0] !== want.led_level)
					note_mismatch("led_level", {31'h0, want.led_level}, {31'h0, m_tdata[0]});
				if (m_tdata[1] !== want.busy_res)
					note_mismatch("busy_res", {31'h0, want.busy_res}, {31'h0, m_tdata[1]});
				if (m_tlast !== want.finished)
					note_mismatch("finished", {31'h0, want.finished}, {31'h0, m_tlast});
				if (m_tdata[7:2] !== 6'h0)
					note_mismatch("tdata padding", 32'h0, {26'h0, m_tdata[7:2]});
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cfg_dot_ticks = DOT_TICKS_RST;
		cfg_on_level = ON_LEVEL_RST;
		cfg_off_level = OFF_LEVEL_RST;
		key_phase = PH_IDLE;
		key_value = '0;
		key_digit = '0;
		key_elem = '0;
		key_ticks = '0;
		key_units = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_register_access();
		test_zero_value();
		test_all_ones_zero_unit();
		test_level_swap();
		test_unit_shrink();
		test_backpressure();
		test_random_traffic(80, 22, 61);
		test_random_traffic(80, 61, 22);
		test_random_traffic(80, 0, 0);

		repeat (5) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
